// ===== sv/accm_pkg.sv =====
`default_nettype none
package accm_pkg;
	localparam int MemWordsDef = 1024;
	localparam int WordBitsDef = 32;
	localparam int AddrBits = 10;
	localparam int IoBits = 32;

	localparam logic [1:0] StatRun = 2'd0;
	localparam logic [1:0] StatStop = 2'd1;
	localparam logic [1:0] StatDivZero = 2'd2;
	localparam logic [1:0] StatIllegal = 2'd3;

	localparam logic [3:0] OpAdd = 4'd1;
	localparam logic [3:0] OpSub = 4'd2;
	localparam logic [3:0] OpMul = 4'd3;
	localparam logic [3:0] OpDiv = 4'd4;
	localparam logic [3:0] OpJmp = 4'd5;
	localparam logic [3:0] OpJmpn = 4'd6;
	localparam logic [3:0] OpJmpp = 4'd7;
	localparam logic [3:0] OpJmpz = 4'd8;
	localparam logic [3:0] OpCopy = 4'd9;
	localparam logic [3:0] OpLoad = 4'd10;
	localparam logic [3:0] OpStore = 4'd11;
	localparam logic [3:0] OpInput = 4'd12;
	localparam logic [3:0] OpOutput = 4'd13;
	localparam logic [3:0] OpStop = 4'd14;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_OP,
		ST_RD_A1,
		ST_RD_A2,
		ST_RD_V,
		ST_CAP_V,
		ST_EXEC,
		ST_DIV,
		ST_DIV_FIX,
		ST_WRITE,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== sv/accm_ram.sv =====
`default_nettype none
module accm_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/accumulator_machine_step.sv =====
// accumulator machine, one item per handshake on each side
// s_axis: tdata from bit 0: address[9:0], data[41:10], in_value[73:42],
//   zero fill to 80 bits; tuser = opcode (0 write word, 1 execute)
// m_axis: tdata from bit 0: pc[9:0], acc[41:10], out_value[73:42], status[75:74],
//   zero fill to 80 bits; tuser = out_valid
// a write command stores its word in WRITE and loads its result in OUT; the next
// word is taken back in IDLE; an execute step reads the opcode, both operand words
// and the operand value through the single read port in RD_OP to RD_V, captures
// the value in CAP_V, runs in EXEC and loads its result in OUT; DIV runs a
// restoring divider one quotient bit per cycle; an execute while halted goes to OUT
// the block takes one word at a time and holds s_axis_tready low while it works
// a stalled receiver keeps the last result in the output register; the block
// still takes and runs the next word, then waits with that result until the
// output register is free
// reset clears pc, acc, status and the output valid; memory content is not
// cleared and must be written before it is read
`default_nettype none
module accumulator_machine_step #(
	parameter int MEM_WORDS = accm_pkg::MemWordsDef,
	parameter int WORD_BITS = accm_pkg::WordBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // address, data, in_value
	input  wire logic        s_axis_tuser,  // opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [79:0] m_axis_tdata,  // pc, acc, out_value, status
	output logic             m_axis_tuser   // out_valid
);
	localparam int AW = $clog2(MEM_WORDS);
	localparam int W = WORD_BITS;
	localparam int CW = $clog2(W + 1);

	accm_pkg::state_t state_q, state_d;

	logic [AW-1:0] pc_q, a1_q, a2_q, waddr, raddr, next_pc;
	logic [W-1:0] acc_q, op_q, v_q, wdata, rdata, in_q, res_acc;
	logic [1:0] stat_q;
	logic we;

	// step result before the output register
	logic res_ok_q;
	logic [W-1:0] res_val_q;

	// divider
	logic [W-1:0] dvd_q, dvs_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic [W:0] trial;

	// output register
	logic [AW-1:0] o_pc_q;
	logic [W-1:0] o_acc_q, o_val_q;
	logic o_ok_q;
	logic [1:0] o_stat_q;
	logic o_vld_q;
	logic o_load;

	accm_ram #(.Width(W), .Depth(MEM_WORDS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic op_legal;
	logic [3:0] op4;
	assign op_legal = (op_q >= W'(1)) && (op_q <= W'(14));
	assign op4 = op_legal ? op_q[3:0] : 4'd0;
	logic acc_neg, v_neg, v_zero, acc_zero;
	assign acc_neg = acc_q[W-1];
	assign v_neg = v_q[W-1];
	assign v_zero = (v_q == '0);
	assign acc_zero = (acc_q == '0);
	assign trial = {rem_q, dvd_q[W-1]} - {1'b0, dvs_q};
	assign o_load = (state_q == accm_pkg::ST_OUT) && (!o_vld_q || m_axis_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			accm_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (!s_axis_tuser) state_d = accm_pkg::ST_WRITE;
					else if (stat_q != accm_pkg::StatRun) state_d = accm_pkg::ST_OUT;
					else state_d = accm_pkg::ST_RD_OP;
				end
			end
			accm_pkg::ST_RD_OP: state_d = accm_pkg::ST_RD_A1;
			accm_pkg::ST_RD_A1: state_d = accm_pkg::ST_RD_A2;
			accm_pkg::ST_RD_A2: state_d = accm_pkg::ST_RD_V;
			accm_pkg::ST_RD_V: state_d = accm_pkg::ST_CAP_V;
			accm_pkg::ST_CAP_V: state_d = accm_pkg::ST_EXEC;
			accm_pkg::ST_EXEC: begin
				if (op4 == accm_pkg::OpDiv && !v_zero) state_d = accm_pkg::ST_DIV;
				else state_d = accm_pkg::ST_OUT;
			end
			accm_pkg::ST_DIV: if (cnt_q == CW'(W - 1)) state_d = accm_pkg::ST_DIV_FIX;
			accm_pkg::ST_DIV_FIX: state_d = accm_pkg::ST_OUT;
			accm_pkg::ST_WRITE: state_d = accm_pkg::ST_OUT;
			accm_pkg::ST_OUT: if (!o_vld_q || m_axis_tready) state_d = accm_pkg::ST_IDLE;
			default: state_d = accm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == accm_pkg::ST_IDLE);
		raddr = pc_q;
		we = 1'b0;
		waddr = a1_q;
		wdata = acc_q;
		unique case (state_q)
			accm_pkg::ST_RD_A1: raddr = pc_q + AW'(1);
			accm_pkg::ST_RD_A2: raddr = pc_q + AW'(2);
			accm_pkg::ST_RD_V: raddr = a1_q;
			accm_pkg::ST_WRITE: begin
				we = 1'b1;
				waddr = a2_q;
				wdata = in_q;
			end
			accm_pkg::ST_EXEC: begin
				unique case (op4)
					accm_pkg::OpCopy: begin
						we = 1'b1;
						waddr = a2_q;
						wdata = v_q;
					end
					accm_pkg::OpStore: we = 1'b1;
					accm_pkg::OpInput: begin
						we = 1'b1;
						wdata = in_q;
					end
					default: we = 1'b0;
				endcase
			end
			default: raddr = pc_q;
		endcase
	end

	always_comb begin
		next_pc = pc_q + AW'(2);
		res_acc = acc_q;
		unique case (op4)
			accm_pkg::OpAdd: res_acc = acc_q + v_q;
			accm_pkg::OpSub: res_acc = acc_q - v_q;
			accm_pkg::OpMul: res_acc = W'(acc_q * v_q);
			accm_pkg::OpDiv: if (v_zero) next_pc = pc_q;
			accm_pkg::OpJmp: next_pc = a1_q;
			accm_pkg::OpJmpn: if (acc_neg) next_pc = a1_q;
			accm_pkg::OpJmpp: if (!acc_neg && !acc_zero) next_pc = a1_q;
			accm_pkg::OpJmpz: if (acc_zero) next_pc = a1_q;
			accm_pkg::OpCopy: next_pc = pc_q + AW'(3);
			accm_pkg::OpLoad: res_acc = v_q;
			accm_pkg::OpStop: next_pc = pc_q + AW'(1);
			accm_pkg::OpStore, accm_pkg::OpInput, accm_pkg::OpOutput: next_pc = pc_q + AW'(2);
			default: next_pc = pc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= accm_pkg::ST_IDLE;
			pc_q <= '0;
			acc_q <= '0;
			stat_q <= accm_pkg::StatRun;
			o_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == accm_pkg::ST_EXEC) begin
				pc_q <= next_pc;
				acc_q <= res_acc;
				if (op4 == accm_pkg::OpStop) stat_q <= accm_pkg::StatStop;
				else if (op4 == 4'd0) stat_q <= accm_pkg::StatIllegal;
				else if (op4 == accm_pkg::OpDiv && v_zero) stat_q <= accm_pkg::StatDivZero;
			end
			if (state_q == accm_pkg::ST_DIV_FIX) begin
				acc_q <= neg_q ? W'(0) - dvd_q : dvd_q;
			end
			if (o_load) o_vld_q <= 1'b1;
			else if (m_axis_tready) o_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			accm_pkg::ST_IDLE: begin
				a2_q <= AW'(s_axis_tdata[9:0]);
				in_q <= s_axis_tuser ? W'($signed(s_axis_tdata[73:42]))
					: W'($signed(s_axis_tdata[41:10]));
				res_ok_q <= 1'b0;
				res_val_q <= '0;
			end
			accm_pkg::ST_RD_A1: op_q <= rdata;
			accm_pkg::ST_RD_A2: a1_q <= AW'(rdata);
			accm_pkg::ST_RD_V: a2_q <= AW'(rdata);
			accm_pkg::ST_CAP_V: v_q <= rdata;
			accm_pkg::ST_EXEC: begin
				if (op4 == accm_pkg::OpOutput) begin
					res_ok_q <= 1'b1;
					res_val_q <= v_q;
				end
				dvd_q <= acc_neg ? W'(0) - acc_q : acc_q;
				dvs_q <= v_neg ? W'(0) - v_q : v_q;
				neg_q <= acc_neg ^ v_neg;
				rem_q <= '0;
				cnt_q <= '0;
			end
			accm_pkg::ST_DIV: begin
				cnt_q <= cnt_q + CW'(1);
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					dvd_q <= {dvd_q[W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[W-2:0], dvd_q[W-1]};
					dvd_q <= {dvd_q[W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// result register loads when the step is done and the register is free
	always_ff @(posedge clk) begin
		if (o_load) begin
			o_pc_q <= pc_q;
			o_acc_q <= acc_q;
			o_val_q <= res_val_q;
			o_ok_q <= res_ok_q;
			o_stat_q <= stat_q;
		end
	end

	logic [63:0] acc_x, val_x;
	assign acc_x = 64'($signed(o_acc_q));
	assign val_x = 64'($signed(o_val_q));
	always_comb begin
		m_axis_tvalid = o_vld_q;
		m_axis_tdata = '0;
		m_axis_tdata[9:0] = 10'(o_pc_q);
		m_axis_tdata[41:10] = acc_x[31:0];
		m_axis_tdata[73:42] = val_x[31:0];
		m_axis_tdata[75:74] = o_stat_q;
		m_axis_tuser = o_ok_q;
	end

	property p_busy;
		@(posedge clk) disable iff (!arst_n)
		(state_q != accm_pkg::ST_IDLE) |-> !s_axis_tready;
	endproperty
	a_busy: assert property (p_busy) else $error("ready while busy");

	property p_halt_hold;
		@(posedge clk) disable iff (!arst_n)
		(stat_q != accm_pkg::StatRun) |=> $stable(pc_q) && $stable(acc_q);
	endproperty
	a_halt_hold: assert property (p_halt_hold) else $error("halted state changed");

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser);
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");
endmodule
`default_nettype wire
